FILE: rtl/rte_pkg.sv
// Revoke table engine: shared types, constants and the wrap-around id compare.
// Used by rte_entry_ram, rte_scan_ctrl and revoke_table_engine; no dependencies.
package rte_pkg;

	localparam int TableDepth = 256;
	localparam int AddrW      = $clog2(TableDepth);
	localparam int CntW       = AddrW + 1;
	localparam int BlkW       = 48;
	localparam int IdW        = 32;
	localparam int EntryW     = BlkW + IdW;
	localparam int CapW       = 9;
	localparam int CapReset   = 256;
	localparam int CountOutW  = 9;
	localparam int InDataW    = ((BlkW + IdW + 7) / 8) * 8;
	localparam int OutDataW   = ((2 + CountOutW + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} rte_state_t;

	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_QUERY  = 1'b1
	} rte_cmd_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              we;
		logic [AddrW-1:0]  waddr;
		logic [BlkW-1:0]   wblk;
		logic [IdW-1:0]    wid;
		logic              re;
		logic [AddrW-1:0]  raddr;
	} rte_mem_req_t;

	typedef struct packed {
		logic                 status;
		logic                 revoked;
		logic [CountOutW-1:0] count;
	} rte_result_t;

	// a is at or after b when the 32-bit difference is non-negative
	function automatic logic id_at_or_after(logic [IdW-1:0] a, logic [IdW-1:0] b);
		logic [IdW-1:0] diff;
		diff = a - b;
		return ~diff[IdW-1];
	endfunction

endpackage

FILE: rtl/revoke_table_engine.sv
// Revoke table engine top level: capacity register, stream ports, result register.
// Instantiates rte_scan_ctrl and rte_entry_ram; depends on rte_pkg.
//
// Usage:
//   Commands arrive on the s_ stream (s_tuser = 0 record, 1 query; s_tdata holds
//   block number and transaction id). Each command yields exactly one result
//   transaction on the m_ stream: status, revoked flag and the entry count.
//   cfg_we/cfg_wdata set the table capacity; write it only while idle.
// Timing:
//   A command scans the table one entry per cycle from a single read port and
//   a single compare unit. With n entries held, a command scans up to n entries
//   (fewer when a record or query hits early). One command is in work at a
//   time; s_tready is high only while the sequencer is idle, so the next
//   command is taken only once the previous result has left the sequencer.
//   The result is held in an output register, so the next command may be taken
//   while m_tvalid waits for m_tready; a stalled receiver stalls the sequencer
//   only when a second result is ready.
// Reset:
//   arst_n empties the table (entry count zero) and sets the capacity to 256.
//   Stored entries are not cleared; only entries below the count are read.
module revoke_table_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rte_pkg::InDataW-1:0]       s_tdata,   // block_number[47:0], transaction_id[79:48]
	input  logic                              s_tuser,   // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rte_pkg::OutDataW-1:0]      m_tdata,   // status[0], revoked[1], entry_count[10:2]
	input  logic                              cfg_we,
	input  logic [rte_pkg::CapW-1:0]          cfg_wdata
);

	logic [rte_pkg::CapW-1:0] cap_q;
	logic                     m_valid_q;
	rte_pkg::rte_result_t     m_res_q;

	logic                     res_valid, res_ready;
	rte_pkg::rte_result_t     res;
	rte_pkg::rte_mem_req_t    mem_req;
	logic [rte_pkg::EntryW-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= rte_pkg::CapW'(rte_pkg::CapReset);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = rte_pkg::OutDataW'({m_res_q.count, m_res_q.revoked, m_res_q.status});

	rte_scan_ctrl u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (cap_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_blk    (s_tdata[rte_pkg::BlkW-1:0]),
		.in_tid    (s_tdata[rte_pkg::BlkW+rte_pkg::IdW-1:rte_pkg::BlkW]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	rte_entry_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

FILE: rtl/rte_entry_ram.sv
// Entry store of the revoke table: block number and id per entry.
// One write port, one read port with registered data. Depends on rte_pkg.
module rte_entry_ram (
	input  logic                             clk,
	input  rte_pkg::rte_mem_req_t            req,
	output logic [rte_pkg::EntryW-1:0]       rdata
);

	logic [rte_pkg::EntryW-1:0] mem [rte_pkg::TableDepth];
	logic [rte_pkg::EntryW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= {req.wblk, req.wid};
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rte_scan_ctrl.sv
// Scan sequencer: walks the entry store one entry per cycle through a single
// block compare and id subtract; a record then updates or appends. Depends on rte_pkg.
module rte_scan_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rte_pkg::CapW-1:0]            capacity,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_cmd,
	input  logic [rte_pkg::BlkW-1:0]            in_blk,
	input  logic [rte_pkg::IdW-1:0]             in_tid,
	output logic                                res_valid,
	input  logic                                res_ready,
	output rte_pkg::rte_result_t                res,
	output rte_pkg::rte_mem_req_t               mem_req,
	input  logic [rte_pkg::EntryW-1:0]          mem_rdata
);

	rte_pkg::rte_state_t        state_q, state_d;
	rte_pkg::rte_cmd_t          cmd_q;
	logic [rte_pkg::BlkW-1:0]   blk_q;
	logic [rte_pkg::IdW-1:0]    tid_q;
	logic [rte_pkg::CntW-1:0]   used_q;
	logic [rte_pkg::CntW-1:0]   limit_q;
	logic [rte_pkg::CntW-1:0]   rd_ptr_q;
	logic                       cmp_vld_q;
	logic [rte_pkg::AddrW-1:0]  cmp_idx_q;
	rte_pkg::rte_result_t       res_q;

	logic [rte_pkg::CntW-1:0]   limit;
	logic [rte_pkg::BlkW-1:0]   rd_blk;
	logic [rte_pkg::IdW-1:0]    rd_id;
	logic [rte_pkg::IdW-1:0]    op_a, op_b;
	logic                       issue, blk_hit, newer;
	logic                       rec_hit, qry_hit, scan_end, finish;
	logic                       full, append;

	assign rd_blk = mem_rdata[rte_pkg::EntryW-1:rte_pkg::IdW];
	assign rd_id  = mem_rdata[rte_pkg::IdW-1:0];

	always_comb begin
		if (int'(capacity) > rte_pkg::TableDepth) begin
			limit = rte_pkg::CntW'(rte_pkg::TableDepth);
		end else begin
			limit = rte_pkg::CntW'(capacity);
		end
	end

	// shared compare unit
	always_comb begin
		if (cmd_q == rte_pkg::CMD_RECORD) begin
			op_a = tid_q;
			op_b = rd_id;
		end else begin
			op_a = rd_id;
			op_b = tid_q;
		end
		newer    = rte_pkg::id_at_or_after(op_a, op_b);
		issue    = (rd_ptr_q < used_q);
		blk_hit  = cmp_vld_q && (rd_blk == blk_q);
		rec_hit  = (cmd_q == rte_pkg::CMD_RECORD) && blk_hit;
		qry_hit  = (cmd_q == rte_pkg::CMD_QUERY) && blk_hit && newer;
		scan_end = !cmp_vld_q && !issue;
		finish   = rec_hit || qry_hit || scan_end;
		full     = (cmd_q == rte_pkg::CMD_RECORD) && scan_end && (used_q >= limit_q);
		append   = (cmd_q == rte_pkg::CMD_RECORD) && scan_end && (used_q < limit_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rte_pkg::ST_IDLE: begin
				if (in_valid) state_d = rte_pkg::ST_SCAN;
			end
			rte_pkg::ST_SCAN: begin
				if (finish) state_d = rte_pkg::ST_DONE;
			end
			rte_pkg::ST_DONE: begin
				if (res_ready) state_d = rte_pkg::ST_IDLE;
			end
			default: state_d = rte_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == rte_pkg::ST_IDLE);
		res_valid     = (state_q == rte_pkg::ST_DONE);
		res           = res_q;
		mem_req.re    = (state_q == rte_pkg::ST_SCAN) && issue;
		mem_req.raddr = rd_ptr_q[rte_pkg::AddrW-1:0];
		mem_req.wblk  = blk_q;
		mem_req.wid   = tid_q;
		mem_req.we    = 1'b0;
		mem_req.waddr = cmp_idx_q;
		if (state_q == rte_pkg::ST_SCAN) begin
			if (rec_hit && newer) begin
				mem_req.we = 1'b1;
			end else if (append) begin
				mem_req.we    = 1'b1;
				mem_req.waddr = used_q[rte_pkg::AddrW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rte_pkg::ST_IDLE;
			used_q    <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rte_pkg::ST_IDLE: begin
					if (in_valid) begin
						cmd_q     <= rte_pkg::rte_cmd_t'(in_cmd);
						blk_q     <= in_blk;
						tid_q     <= in_tid;
						limit_q   <= limit;
						rd_ptr_q  <= '0;
						cmp_vld_q <= 1'b0;
					end
				end
				rte_pkg::ST_SCAN: begin
					rd_ptr_q  <= rd_ptr_q + rte_pkg::CntW'(issue);
					cmp_vld_q <= issue;
					cmp_idx_q <= rd_ptr_q[rte_pkg::AddrW-1:0];
					if (finish) begin
						res_q.status  <= full ? rte_pkg::STATUS_FULL : rte_pkg::STATUS_OK;
						res_q.revoked <= qry_hit;
						res_q.count   <= rte_pkg::CountOutW'(used_q + rte_pkg::CntW'(append));
						if (append) used_q <= used_q + rte_pkg::CntW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
